// ===== rtl/crc16_packet_receiver_with_ack_macros.svh =====
// assertion macros for the crc16 packet receiver checker
`ifndef CRC16_PACKET_RECEIVER_WITH_ACK_MACROS_SVH
`define CRC16_PACKET_RECEIVER_WITH_ACK_MACROS_SVH

// same-cycle implication
`define CRCRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crcrx check failed");

// next-cycle implication
`define CRCRX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crcrx check failed");

`endif

// ===== rtl/crcrx_pkg.sv =====
// shared types, constants and crc function of the crc16 packet receiver
package crcrx_pkg;

  localparam logic [7:0]  FRAME_START    = 8'hEB;
  localparam logic [15:0] CRC_POLY       = 16'h8005;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [7:0]  MAX_LEN_RESET  = 8'hFF;
  localparam int unsigned FRAME_OVERHEAD = 5;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DUP  = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;
  localparam logic [1:0] KIND_READ = 2'd3;

  localparam logic [2:0] OFF_ONE  = 3'd0;
  localparam logic [2:0] OFF_TWO  = 3'd1;
  localparam logic [2:0] OFF_LEN3 = 3'd2;
  localparam logic [2:0] OFF_LEN4 = 3'd3;
  localparam logic [2:0] OFF_K3   = 3'd4;
  localparam logic [2:0] OFF_K    = 3'd5;

  localparam logic [1:0] K_KEEP = 2'd0;
  localparam logic [1:0] K_CLR  = 2'd1;
  localparam logic [1:0] K_ONE  = 2'd2;
  localparam logic [1:0] K_INC  = 2'd3;

  localparam logic [1:0] CONS_NONE  = 2'd0;
  localparam logic [1:0] CONS_FRAME = 2'd1;
  localparam logic [1:0] CONS_K     = 2'd2;
  localparam logic [1:0] CONS_FILL  = 2'd3;

  typedef struct packed {
    logic       wr_line;
    logic       line_re;
    logic [2:0] off_sel;
    logic [1:0] k_op;
    logic       cap_len;
    logic       cap_seq;
    logic       cap_chi;
    logic       cap_clo;
    logic       crc_init;
    logic       crc_step;
    logic       del_we;
    logic       del_re;
    logic       seq_upd;
    logic       out_load;
    logic [1:0] out_kind;
    logic [1:0] cons;
  } cmd_t;

  typedef struct packed {
    logic fill_lt5;
    logic len_bad;
    logic len_short;
    logic len_zero;
    logic k_last;
    logic k_end;
    logic byte_start;
    logic crc_ok;
    logic dup;
    logic out_free;
  } sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/crcrx_if.sv =====
// valid/ready channel interfaces of the crc16 packet receiver
interface crcrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] line_byte;
  logic [7:0] read_index;
  modport source (output valid, op, line_byte, read_index, input ready);
  modport sink (input valid, op, line_byte, read_index, output ready);
endinterface

interface crcrx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        send_ack;
  logic [7:0]  seq_id;
  logic [15:0] crc_field;
  logic [7:0]  data_len;
  logic [7:0]  data_byte;
  modport source (output valid, kind, send_ack, seq_id, crc_field, data_len, data_byte,
                  input ready);
  modport sink (input valid, kind, send_ack, seq_id, crc_field, data_len, data_byte,
                output ready);
endinterface

interface crcrx_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/crcrx_ram.sv =====
// generic single write, single registered read ram
module crcrx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/crcrx_dp.sv =====
// datapath: line ring buffer, delivered store, crc unit and result register
module crcrx_dp #(
  parameter int unsigned DEPTH = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crcrx_pkg::cmd_t   cmd_i,
  output crcrx_pkg::sts_t   sts_o,
  input  logic [7:0]        in_byte_i,
  input  logic [7:0]        in_index_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        kind_o,
  output logic              send_ack_o,
  output logic [7:0]        seq_id_o,
  output logic [15:0]       crc_field_o,
  output logic [7:0]        data_len_o,
  output logic [7:0]        data_byte_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned SW = PW + 1;

  logic [AW-1:0] head_q, head_d;
  logic [PW-1:0] fill_q, fill_d;
  logic [PW-1:0] k_q, k_d;
  logic [7:0]    len_q, seq_q, last_seq_q, max_len_q;
  logic          seq_valid_q;
  logic [15:0]   crc_rx_q, crc_q;
  logic [PW-1:0] off, cons_amt;
  logic [SW-1:0] rd_sum, wr_sum, hd_sum;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_ok;
  logic [7:0]    line_rdata, del_rdata;

  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic          send_ack_q;
  logic [7:0]    seq_id_q, data_len_q, data_byte_q;
  logic [15:0]   crc_field_q;

  always_comb begin
    case (cmd_i.k_op)
      crcrx_pkg::K_CLR: k_d = '0;
      crcrx_pkg::K_ONE: k_d = PW'(1);
      crcrx_pkg::K_INC: k_d = k_q + PW'(1);
      default:          k_d = k_q;
    endcase
    case (cmd_i.off_sel)
      crcrx_pkg::OFF_ONE:  off = PW'(1);
      crcrx_pkg::OFF_TWO:  off = PW'(2);
      crcrx_pkg::OFF_LEN3: off = PW'(len_q) + PW'(3);
      crcrx_pkg::OFF_LEN4: off = PW'(len_q) + PW'(4);
      crcrx_pkg::OFF_K3:   off = k_d + PW'(3);
      crcrx_pkg::OFF_K:    off = k_d;
      default:             off = '0;
    endcase
    case (cmd_i.cons)
      crcrx_pkg::CONS_FRAME: cons_amt = PW'(len_q) + PW'(crcrx_pkg::FRAME_OVERHEAD);
      crcrx_pkg::CONS_K:     cons_amt = k_q;
      crcrx_pkg::CONS_FILL:  cons_amt = fill_q;
      default:               cons_amt = '0;
    endcase
  end

  // ring addressing, sums stay below twice the depth
  assign rd_sum  = SW'(head_q) + SW'(off);
  assign rd_addr = (rd_sum >= SW'(DEPTH)) ? AW'(rd_sum - SW'(DEPTH)) : AW'(rd_sum);
  assign wr_sum  = SW'(head_q) + SW'(fill_q);
  assign wr_addr = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : AW'(wr_sum);
  assign hd_sum  = SW'(head_q) + SW'(cons_amt);
  assign head_d  = (hd_sum >= SW'(DEPTH)) ? AW'(hd_sum - SW'(DEPTH)) : AW'(hd_sum);

  assign wr_ok  = cmd_i.wr_line && (fill_q < PW'(DEPTH)) &&
                  ((fill_q != '0) || (in_byte_i == crcrx_pkg::FRAME_START));
  assign fill_d = wr_ok ? fill_q + PW'(1) : fill_q - cons_amt;

  crcrx_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_byte_i),
    .re_i    (cmd_i.line_re),
    .raddr_i (rd_addr),
    .rdata_o (line_rdata)
  );

  crcrx_ram #(.WIDTH(8), .DEPTH(256)) u_del_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.del_we),
    .waddr_i (k_q[7:0]),
    .wdata_i (line_rdata),
    .re_i    (cmd_i.del_re),
    .raddr_i (in_index_i),
    .rdata_o (del_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      last_seq_q  <= '0;
      seq_valid_q <= 1'b0;
      max_len_q   <= crcrx_pkg::MAX_LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      k_q    <= k_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (cmd_i.seq_upd) begin
        last_seq_q  <= seq_q;
        seq_valid_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_len) begin
      len_q <= line_rdata;
    end
    if (cmd_i.cap_seq) begin
      seq_q <= line_rdata;
    end
    if (cmd_i.cap_chi) begin
      crc_rx_q[15:8] <= line_rdata;
    end
    if (cmd_i.cap_clo) begin
      crc_rx_q[7:0] <= line_rdata;
    end
    if (cmd_i.crc_init) begin
      crc_q <= crcrx_pkg::CRC_INIT;
    end else if (cmd_i.crc_step) begin
      crc_q <= crcrx_pkg::crc_byte(crc_q, line_rdata);
    end
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_kind;
      if (cmd_i.out_kind == crcrx_pkg::KIND_READ) begin
        send_ack_q  <= 1'b0;
        seq_id_q    <= '0;
        crc_field_q <= '0;
        data_len_q  <= '0;
        data_byte_q <= del_rdata;
      end else begin
        send_ack_q  <= (cmd_i.out_kind != crcrx_pkg::KIND_ACK);
        seq_id_q    <= seq_q;
        crc_field_q <= crc_rx_q;
        data_len_q  <= len_q;
        data_byte_q <= '0;
      end
    end
  end

  assign sts_o.fill_lt5   = fill_q < PW'(crcrx_pkg::FRAME_OVERHEAD);
  assign sts_o.len_bad    = line_rdata > max_len_q;
  assign sts_o.len_short  = fill_q < (PW'(line_rdata) + PW'(crcrx_pkg::FRAME_OVERHEAD));
  assign sts_o.len_zero   = len_q == '0;
  assign sts_o.k_last     = (k_q + PW'(1)) == PW'(len_q);
  assign sts_o.k_end      = k_q >= fill_q;
  assign sts_o.byte_start = line_rdata == crcrx_pkg::FRAME_START;
  assign sts_o.crc_ok     = crc_q == crc_rx_q;
  assign sts_o.dup        = seq_valid_q && (last_seq_q == seq_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign send_ack_o  = send_ack_q;
  assign seq_id_o    = seq_id_q;
  assign crc_field_o = crc_field_q;
  assign data_len_o  = data_len_q;
  assign data_byte_o = data_byte_q;
endmodule

// ===== rtl/crcrx_ctrl.sv =====
// controller: sequences buffer reads, crc pass, copy and resync scan
module crcrx_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_op_i,
  input  crcrx_pkg::sts_t sts_i,
  output crcrx_pkg::cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_SEQ  = 4'd3;
  localparam logic [3:0] S_CHI  = 4'd4;
  localparam logic [3:0] S_CLO  = 4'd5;
  localparam logic [3:0] S_CRC  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_CPY  = 4'd8;
  localparam logic [3:0] S_SCAN = 4'd9;
  localparam logic [3:0] S_SCHK = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            crcrx_pkg::OP_BYTE: begin
              cmd_o.wr_line = 1'b1;
              state_d       = S_DEC;
            end
            crcrx_pkg::OP_POLL: state_d = S_DEC;
            crcrx_pkg::OP_READ: begin
              cmd_o.del_re = 1'b1;
              kind_d       = crcrx_pkg::KIND_READ;
              state_d      = S_OUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DEC: begin
        if (sts_i.fill_lt5) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.line_re = 1'b1;
          cmd_o.off_sel = crcrx_pkg::OFF_ONE;
          state_d       = S_LEN;
        end
      end
      S_LEN: begin
        cmd_o.cap_len = 1'b1;
        if (sts_i.len_bad) begin
          cmd_o.k_op = crcrx_pkg::K_ONE;
          state_d    = S_SCAN;
        end else if (sts_i.len_short) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.line_re = 1'b1;
          cmd_o.off_sel = crcrx_pkg::OFF_TWO;
          state_d       = S_SEQ;
        end
      end
      S_SEQ: begin
        cmd_o.cap_seq = 1'b1;
        cmd_o.line_re = 1'b1;
        cmd_o.off_sel = crcrx_pkg::OFF_LEN3;
        state_d       = S_CHI;
      end
      S_CHI: begin
        cmd_o.cap_chi = 1'b1;
        cmd_o.line_re = 1'b1;
        cmd_o.off_sel = crcrx_pkg::OFF_LEN4;
        state_d       = S_CLO;
      end
      S_CLO: begin
        cmd_o.cap_clo = 1'b1;
        if (sts_i.len_zero) begin
          kind_d  = crcrx_pkg::KIND_ACK;
          state_d = S_OUT;
        end else begin
          cmd_o.crc_init = 1'b1;
          cmd_o.k_op     = crcrx_pkg::K_CLR;
          cmd_o.line_re  = 1'b1;
          cmd_o.off_sel  = crcrx_pkg::OFF_K3;
          state_d        = S_CRC;
        end
      end
      S_CRC: begin
        cmd_o.crc_step = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_CHK;
        end else begin
          cmd_o.k_op    = crcrx_pkg::K_INC;
          cmd_o.line_re = 1'b1;
          cmd_o.off_sel = crcrx_pkg::OFF_K3;
        end
      end
      S_CHK: begin
        if (!sts_i.crc_ok) begin
          cmd_o.k_op = crcrx_pkg::K_ONE;
          state_d    = S_SCAN;
        end else if (sts_i.dup) begin
          kind_d  = crcrx_pkg::KIND_DUP;
          state_d = S_OUT;
        end else begin
          cmd_o.k_op    = crcrx_pkg::K_CLR;
          cmd_o.line_re = 1'b1;
          cmd_o.off_sel = crcrx_pkg::OFF_K3;
          state_d       = S_CPY;
        end
      end
      S_CPY: begin
        cmd_o.del_we = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.seq_upd = 1'b1;
          kind_d        = crcrx_pkg::KIND_DATA;
          state_d       = S_OUT;
        end else begin
          cmd_o.k_op    = crcrx_pkg::K_INC;
          cmd_o.line_re = 1'b1;
          cmd_o.off_sel = crcrx_pkg::OFF_K3;
        end
      end
      S_SCAN: begin
        if (sts_i.k_end) begin
          cmd_o.cons = crcrx_pkg::CONS_FILL;
          state_d    = S_IDLE;
        end else begin
          cmd_o.line_re = 1'b1;
          cmd_o.off_sel = crcrx_pkg::OFF_K;
          state_d       = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts_i.byte_start) begin
          cmd_o.cons = crcrx_pkg::CONS_K;
          state_d    = S_IDLE;
        end else begin
          cmd_o.k_op = crcrx_pkg::K_INC;
          state_d    = S_SCAN;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = kind_q;
          cmd_o.cons     = (kind_q == crcrx_pkg::KIND_READ) ? crcrx_pkg::CONS_NONE
                                                             : crcrx_pkg::CONS_FRAME;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= crcrx_pkg::KIND_DATA;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end
endmodule

// ===== rtl/crc16_packet_receiver_with_ack.sv =====
// top level of the crc16 stop-and-wait packet receiver
//
//   channel  dir  payload
//   in_i     in   op, line_byte, read_index
//   out_o    out  kind, send_ack, seq_id, crc_field, data_len, data_byte
//   cfg_i    in   data (max_data_length)
//
// the controller issues at most one buffer ram read per cycle
// a good frame takes a crc pass and a copy pass, a duplicate only the crc pass;
// a bad crc or an oversize length starts a resync scan for the next start byte;
// too few buffered bytes end the item with no result, a zero length gives an ack
// reset clears fill, sequence state and max_data_length to 255; no clearing pass
// a result waits in the output register while the next item is taken in; a decision
// that reaches its result stalls while that register is full and out_o is not ready
module crc16_packet_receiver_with_ack #(
  parameter int unsigned LINE_BUFFER_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crcrx_in_if.sink    in_i,
  crcrx_out_if.source out_o,
  crcrx_cfg_if.sink   cfg_i
);
  crcrx_pkg::cmd_t cmd;
  crcrx_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  crcrx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_op_i    (in_i.op),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crcrx_dp #(.DEPTH(LINE_BUFFER_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (in_i.line_byte),
    .in_index_i  (in_i.read_index),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .kind_o      (out_o.kind),
    .send_ack_o  (out_o.send_ack),
    .seq_id_o    (out_o.seq_id),
    .crc_field_o (out_o.crc_field),
    .data_len_o  (out_o.data_len),
    .data_byte_o (out_o.data_byte)
  );
endmodule

// ===== rtl/crcrx_checker.sv =====
// port checker of the crc16 packet receiver and its bind
`include "crc16_packet_receiver_with_ack_macros.svh"

module crcrx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic        send_ack_i,
  input logic [7:0]  seq_id_i,
  input logic [15:0] crc_field_i,
  input logic [7:0]  data_len_i,
  input logic [7:0]  data_byte_i
);
  logic out_wait, read_out, ack_out, data_out, in_taken;
  logic read_clean, ack_clean, data_clean;

  assign out_wait   = out_valid_i && !out_ready_i;
  assign read_out   = out_valid_i && (kind_i == crcrx_pkg::KIND_READ);
  assign ack_out    = out_valid_i && (kind_i == crcrx_pkg::KIND_ACK);
  assign data_out   = out_valid_i &&
                      ((kind_i == crcrx_pkg::KIND_DATA) || (kind_i == crcrx_pkg::KIND_DUP));
  assign in_taken   = in_valid_i && in_ready_i && (in_op_i != crcrx_pkg::OP_RSVD);
  assign read_clean = !send_ack_i && (seq_id_i == 8'd0) && (crc_field_i == 16'd0) &&
                      (data_len_i == 8'd0);
  assign ack_clean  = !send_ack_i && (data_len_i == 8'd0) && (data_byte_i == 8'd0);
  assign data_clean = send_ack_i && (data_len_i != 8'd0) && (data_byte_i == 8'd0);

  `CRCRX_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_i)
  `CRCRX_ASSERT_IMP(a_read_clean, clk_i, rst_ni, read_out, read_clean)
  `CRCRX_ASSERT_IMP(a_ack_kind, clk_i, rst_ni, ack_out, ack_clean)
  `CRCRX_ASSERT_IMP(a_data_kind, clk_i, rst_ni, data_out, data_clean)
  `CRCRX_ASSERT_NXT(a_in_busy, clk_i, rst_ni, in_taken, !in_ready_i)
endmodule

bind crc16_packet_receiver_with_ack crcrx_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .send_ack_i  (out_o.send_ack),
  .seq_id_i    (out_o.seq_id),
  .crc_field_i (out_o.crc_field),
  .data_len_i  (out_o.data_len),
  .data_byte_i (out_o.data_byte)
);
